[hw/rtl/range_argmax_segment_tree_top_defines.svh]
// ----------------------------------------------------------------------------
// Range argmax segment tree: assertion macros
// Shared concurrent assertion forms for the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef RANGE_ARGMAX_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_ARGMAX_SEGMENT_TREE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rast_pkg.sv]
// ----------------------------------------------------------------------------
// rast_pkg
// Operation codes and sequencer states of the range argmax segment tree.
// ----------------------------------------------------------------------------
package rast_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_INS   = 5'b00100,
    ST_QSTEP = 5'b01000,
    ST_QACC  = 5'b10000
  } rast_state_t;

endpackage

[hw/rtl/range_argmax_segment_tree_top.sv]
// ----------------------------------------------------------------------------
// range_argmax_segment_tree_top
// Segment tree of node winners answering inserts and range argmax queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: an insert writes
//   in_key at in_position, a query asks for the highest-key position within
//   [in_range_low, in_range_high]; equal keys go to the higher position.
//   Each query returns one result on the out_ channel (out_valid / out_stall);
//   inserts return nothing. Inserts above last_position are dropped.
//   The config channel (cfg_valid / cfg_ready) writes last_position; every
//   write restarts the clearing pass and empties the tree.
// Sequencing:
//   One request at a time; in_stall is high while a request is in work.
//   Insert: the leaf is written when the request is taken, then ST_INS writes
//   one parent per tree level, one node memory write and read per level.
//   Query: per tree level one shift step, plus a read step and a combine step
//   for each of at most two nodes read from the node memory.
// Reset and stall:
//   After reset and after each config write, a clearing pass writes all
//   2*POSITIONS node entries, one per cycle, with in_stall held high.
//   A result held by out_stall stays in the output register; a finishing
//   query waits in ST_QSTEP until the output register is free.
// ----------------------------------------------------------------------------
module range_argmax_segment_tree_top
  import rast_pkg::*;
#(
  parameter int POSITIONS = 1024,
  parameter int KEY_BITS  = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [$clog2(POSITIONS)-1:0]         in_position,
  input  logic signed [KEY_BITS-1:0]           in_key,
  input  logic [$clog2(POSITIONS)-1:0]         in_range_low,
  input  logic [$clog2(POSITIONS)-1:0]         in_range_high,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [$clog2(POSITIONS)-1:0]         out_best_position,
  output logic signed [KEY_BITS-1:0]           out_best_key,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [$clog2(POSITIONS)-1:0]         cfg_data
);

  localparam int PB    = $clog2(POSITIONS);
  localparam int NODES = 2 * POSITIONS;
  localparam int NB    = $clog2(NODES);
  localparam int EW    = 1 + PB + KEY_BITS;

  typedef struct packed {
    logic                       vld;
    logic [PB-1:0]              pos;
    logic signed [KEY_BITS-1:0] key;
  } entry_t;

  function automatic entry_t better(entry_t a, entry_t b);
    entry_t res;
    priority if (!a.vld) res = b;
    else if (!b.vld) res = a;
    else if ($signed(a.key) > $signed(b.key)) res = a;
    else if ($signed(b.key) > $signed(a.key)) res = b;
    else if (a.pos > b.pos) res = a;
    else res = b;
    return res;
  endfunction

  rast_state_t  state_r, state_nxt;
  logic [NB-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [PB-1:0] last_pos_r, last_pos_nxt;
  logic [NB-1:0] node_r, node_nxt;
  entry_t        cur_r, cur_nxt;
  logic [NB:0]   l_r, l_nxt;
  logic [NB:0]   r_r, r_nxt;
  entry_t        best_r, best_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [PB-1:0]              out_pos_r, out_pos_nxt;
  logic signed [KEY_BITS-1:0] out_key_r, out_key_nxt;

  logic          ram_we;
  logic [NB-1:0] ram_waddr;
  logic [NB-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic [EW-1:0] ram_rdata_raw;

  logic          in_acc;
  logic          cfg_acc;
  logic [NB-1:0] leaf_idx;
  logic [NB-1:0] parent;
  logic [NB:0]   r_dec;
  logic [PB-1:0] hi_clip;
  entry_t        comb_w;

  rast_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign leaf_idx = NB'(in_position) + NB'(POSITIONS);
  assign parent   = node_r >> 1;
  assign r_dec    = r_r - (NB + 1)'(1);
  assign hi_clip  = (in_range_high > last_pos_r) ? last_pos_r : in_range_high;
  assign comb_w   = better(cur_r, ram_rdata);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    last_pos_nxt  = last_pos_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_key_nxt   = out_key_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == NB'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + NB'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_INSERT) begin
            // drop inserts beyond the covered range
            if (in_position <= last_pos_r) begin
              ram_we        = 1'b1;
              ram_waddr     = leaf_idx;
              ram_wdata.vld = 1'b1;
              ram_wdata.pos = in_position;
              ram_wdata.key = in_key;
              cur_nxt       = ram_wdata;
              node_nxt      = leaf_idx;
              ram_raddr     = leaf_idx ^ NB'(1);
              state_nxt     = ST_INS;
            end
          end else begin
            // an empty range leaves l >= r and finishes at once
            l_nxt     = (NB + 1)'(in_range_low) + (NB + 1)'(POSITIONS);
            r_nxt     = (NB + 1)'(hi_clip) + (NB + 1)'(POSITIONS) + (NB + 1)'(1);
            best_nxt  = '0;
            state_nxt = ST_QSTEP;
          end
        end
      end
      ST_INS: begin
        // combine with the sibling, write the parent, fetch its sibling
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = comb_w;
        cur_nxt   = comb_w;
        node_nxt  = parent;
        ram_raddr = parent ^ NB'(1);
        if (parent == NB'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QSTEP: begin
        priority if (l_r >= r_r) begin
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = best_r.vld;
            out_pos_nxt   = best_r.vld ? best_r.pos : '0;
            out_key_nxt   = best_r.vld ? best_r.key : '0;
            state_nxt     = ST_IDLE;
          end
        end else if (l_r[0]) begin
          ram_raddr = l_r[NB-1:0];
          l_nxt     = l_r + (NB + 1)'(1);
          state_nxt = ST_QACC;
        end else if (r_r[0]) begin
          ram_raddr = r_dec[NB-1:0];
          r_nxt     = r_dec;
          state_nxt = ST_QACC;
        end else begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end
      end
      ST_QACC: begin
        best_nxt  = better(best_r, ram_rdata);
        state_nxt = ST_QSTEP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a config write reshapes the tree: restart the clearing pass
    if (cfg_acc) begin
      last_pos_nxt = (cfg_data > PB'(POSITIONS - 1)) ? PB'(POSITIONS - 1) : cfg_data;
      clr_cnt_nxt  = '0;
      state_nxt    = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      last_pos_r  <= PB'(POSITIONS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      last_pos_r  <= last_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    cur_r       <= cur_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    best_r      <= best_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_key_r   <= out_key_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_best_position = out_pos_r;
  assign out_best_key      = out_key_r;

endmodule

[hw/rtl/rast_ram.sv]
// ----------------------------------------------------------------------------
// rast_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rast_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rast_checker.sv]
// ----------------------------------------------------------------------------
// rast_checker
// Port-level assertions for the range argmax segment tree, bound to the top.
// ----------------------------------------------------------------------------
`include "range_argmax_segment_tree_top_defines.svh"

module rast_checker
  import rast_pkg::*;
#(
  parameter int POSITIONS = 1024,
  parameter int KEY_BITS  = 12
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_operation,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic [$clog2(POSITIONS)-1:0] out_best_position,
  input logic signed [KEY_BITS-1:0]   out_best_key,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  // a stalled result holds
  `RAST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_best_position) && $stable(out_best_key), "stalled result changed")

  // an empty answer carries zero payload
  `RAST_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !out_found, out_best_position == '0 && out_best_key == '0, "empty result with nonzero payload")

  // the clearing pass blocks requests right after reset
  `RAST_ASSERT_NOW(a_clear_after_reset, clk, rst_n, $past(!rst_n), in_stall, "request taken during clearing pass")

  // a config write restarts clearing; a query keeps the block busy
  `RAST_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_valid && cfg_ready, in_stall, "request taken after config write")
  `RAST_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && in_operation == OP_QUERY, in_stall, "block idle right after query")

endmodule

bind range_argmax_segment_tree_top rast_checker #(
  .POSITIONS (POSITIONS),
  .KEY_BITS  (KEY_BITS)
) u_rast_checker (.*);
